/* sv/motor_velocity_ramp_pd_controller_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the velocity ramp PD controller
// Concurrent checks that compile away when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef MOTOR_VELOCITY_RAMP_PD_CONTROLLER_DEFINES_SVH
`define MOTOR_VELOCITY_RAMP_PD_CONTROLLER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define MVR_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("implication check failed");
// next-cycle implication
`define MVR_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");
`else
`define MVR_ASSERT_IMPL(label, clk, rst_n, pre, post)
`define MVR_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif

`endif

/* sv/mvr_pkg.sv */
// ---------------------------------------------------------------------------
// mvr_pkg
// Shared constants, register codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package mvr_pkg;

    // field widths
    localparam int DELTA_W    = 16;
    localparam int TARGET_W   = 24;
    localparam int GAIN_W     = 16;
    localparam int EFFORT_W   = 22;
    localparam int DUTY_W     = 16;
    localparam int MEAS_OUT_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // stream packing
    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_PAD_W  = OUT_DATA_W - (DUTY_W + 1 + EFFORT_W + MEAS_OUT_W);

    localparam int HISTORY_DEPTH = 4;

    // 33.372 mm/s per count in Q.8
    localparam logic [14:0] VEL_PER_COUNT = 15'd8543;

    // accumulator clamp, 7700 in Q.8
    localparam logic signed [EFFORT_W-1:0] EFFORT_LIMIT = 22'sd1971200;
    localparam logic signed [EFFORT_W-1:0] EFFORT_NEG   = -22'sd1971200;

    // pwm scaling: limit = PWM_DIVISOR * 2^PWM_PRE_SHIFT
    localparam logic [10:0] PWM_DIVISOR   = 11'd1925;
    localparam int          PWM_PRE_SHIFT = 10;
    localparam int          PWM_NUM_W     = 27;

    // floor(n / PWM_DIVISOR) = (n * PWM_RECIP) >> PWM_RECIP_SHIFT for n below 2^27
    localparam int                     PWM_RECIP_W     = 28;
    localparam logic [PWM_RECIP_W-1:0] PWM_RECIP       = 28'd142793718;
    localparam int                     PWM_RECIP_SHIFT = 38;

    // fixed-point shifts
    localparam int HG_SHIFT = 14;
    localparam int PD_SHIFT = 12;

    // shared multiplier: one nibble of the gain per step
    localparam int NIB_W     = 4;
    localparam int MUL_STEPS = GAIN_W / NIB_W;

    // register reset values
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST   = 16'd1720;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST  = 16'd2540;
    localparam logic [GAIN_W-1:0] RAMP_STEP_RST   = 16'd448;
    localparam logic [GAIN_W-1:0] HANDLE_GAIN_RST = 16'd16384;
    localparam logic [GAIN_W-1:0] PWM_PERIOD_RST  = 16'd8399;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN   = 3'd0,
        CFG_DERIV_GAIN  = 3'd1,
        CFG_RAMP_STEP   = 3'd2,
        CFG_HANDLE_GAIN = 3'd3,
        CFG_PWM_PERIOD  = 3'd4,
        CFG_DIR_INVERT  = 3'd5
    } t_cfg_index;

    typedef enum logic [1:0] {
        MSEL_HG  = 2'd0,
        MSEL_KP  = 2'd1,
        MSEL_KD  = 2'd2,
        MSEL_PWM = 2'd3
    } t_mul_sel;

    typedef struct packed {
        logic     load_in;
        logic     calc_vel;
        logic     calc_meas;
        logic     mul_start;
        t_mul_sel mul_sel;
        logic     calc_err;
        logic     calc_diff;
        logic     latch_p;
        logic     calc_acc;
        logic     div_start;
        logic     load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic enable;
        logic mul_busy;
        logic mul_done;
        logic div_done;
    } t_dp_status;

endpackage

/* sv/motor_velocity_ramp_pd_controller.sv */
// ---------------------------------------------------------------------------
// motor_velocity_ramp_pd_controller
// One motor axis per tick: velocity estimate, setpoint ramp, incremental PD.
// ---------------------------------------------------------------------------
// Usage:
//   One input beat per control tick on the s_axis channel; one result beat
//   per input beat on the m_axis channel. Gains, ramp step, handle gain,
//   pwm period and direction sense are written through the cfg port while
//   no tick is in flight.
// Tick sequence:
//   An enabled tick makes four passes through the shared 4-bit-digit
//   multiplier and then the reciprocal pwm divide before its result is
//   valid; a disabled tick skips them. The next beat is accepted in the cycle
//   after the result is loaded, so ticks do not overlap.
// Reset:
//   Registers return to their default values; setpoint, previous velocity,
//   error history and accumulator clear; both channels go idle.
// Stall:
//   A finished result waits in the output register; a new input beat is taken
//   meanwhile, and its result waits in the last step until the slot frees.
// ---------------------------------------------------------------------------
`include "motor_velocity_ramp_pd_controller_defines.svh"

module motor_velocity_ramp_pd_controller import mvr_pkg::*; #(
    parameter int VEL_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // encoder_delta, target_velocity
    input  logic [IN_USER_W-1:0]  s_axis_tuser,   // enable
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // pwm_duty, drive_direction,
                                                  // control_effort, measured_velocity
);

    t_dp_cmd                      w_cmd;
    t_dp_status                   w_status;
    logic [DUTY_W-1:0]            w_duty;
    logic                         w_dir;
    logic signed [EFFORT_W-1:0]   w_effort;
    logic signed [MEAS_OUT_W-1:0] w_meas;

    mvr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    mvr_datapath #(
        .VEL_WIDTH (VEL_WIDTH)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_encoder_delta     (s_axis_tdata[DELTA_W-1:0]),
        .i_target_velocity   (s_axis_tdata[DELTA_W+TARGET_W-1:DELTA_W]),
        .i_enable            (s_axis_tuser[0]),
        .i_cmd               (w_cmd),
        .o_status            (w_status),
        .o_pwm_duty          (w_duty),
        .o_drive_direction   (w_dir),
        .o_control_effort    (w_effort),
        .o_measured_velocity (w_meas)
    );

    // pack the result beat, lowest field first
    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, w_meas, w_effort, w_dir, w_duty};

    // checks
    `MVR_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `MVR_ASSERT_IMPL(a_mul_no_restart, i_clk, i_rst_n, w_cmd.mul_start, !w_status.mul_busy)
    `MVR_ASSERT_IMPL(a_dir_needs_duty, i_clk, i_rst_n, m_axis_tvalid && w_dir, w_duty != '0)
    `MVR_ASSERT_IMPL(a_effort_range, i_clk, i_rst_n, m_axis_tvalid, (w_effort <= EFFORT_LIMIT) && (w_effort >= EFFORT_NEG))

endmodule

/* sv/mvr_mul.sv */
// ---------------------------------------------------------------------------
// mvr_mul
// Shared signed-by-unsigned multiplier, one 4-bit gain digit per cycle.
// ---------------------------------------------------------------------------
module mvr_mul import mvr_pkg::*; #(
    parameter int A_W = 35
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic signed [A_W-1:0]       i_a,
    input  logic [GAIN_W-1:0]           i_b,
    output logic signed [A_W+GAIN_W-1:0] o_prod,
    output logic                        o_busy,
    output logic                        o_done
);

    localparam int P_W   = A_W + GAIN_W;
    localparam int CNT_W = $clog2(MUL_STEPS);

    logic signed [A_W-1:0]   r_a;
    logic [GAIN_W-1:0]       r_b;
    logic signed [P_W-1:0]   r_prod;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_busy;
    logic                    r_done;
    logic signed [A_W+NIB_W:0] w_part;

    // partial product of the top remaining digit
    assign w_part = r_a * $signed({1'b0, r_b[GAIN_W-1 -: NIB_W]});

    // sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operands and product, most significant digit first
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a    <= i_a;
            r_b    <= i_b;
            r_prod <= '0;
        end else if (r_busy) begin
            r_b    <= r_b << NIB_W;
            r_prod <= (r_prod <<< NIB_W) + P_W'(w_part);
        end
    end

    assign o_prod = r_prod;
    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

/* sv/mvr_div.sv */
// ---------------------------------------------------------------------------
// mvr_div
// Divide by the fixed pwm divisor through a reciprocal multiply, registered.
// ---------------------------------------------------------------------------
module mvr_div import mvr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [PWM_NUM_W-1:0] i_num,
    output logic [DUTY_W-1:0]    o_quot,
    output logic                 o_done
);

    localparam int RP_W = PWM_NUM_W + PWM_RECIP_W;

    logic [DUTY_W-1:0] r_quot;
    logic              r_done;
    logic [RP_W-1:0]   w_rprod;

    // numerator is below divisor * 2^16, so the quotient fits the duty field
    assign w_rprod = RP_W'(i_num) * RP_W'(PWM_RECIP);

    // done registered, in the cycle after start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    // quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= w_rprod[PWM_RECIP_SHIFT +: DUTY_W];
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

endmodule

/* sv/mvr_datapath.sv */
// ---------------------------------------------------------------------------
// mvr_datapath
// Velocity, ramp, error history, PD accumulator and pwm scaling registers.
// ---------------------------------------------------------------------------
module mvr_datapath import mvr_pkg::*; #(
    parameter int VEL_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic signed [DELTA_W-1:0]  i_encoder_delta,
    input  logic signed [TARGET_W-1:0] i_target_velocity,
    input  logic                       i_enable,
    input  t_dp_cmd                    i_cmd,
    output t_dp_status                 o_status,
    output logic [DUTY_W-1:0]          o_pwm_duty,
    output logic                       o_drive_direction,
    output logic signed [EFFORT_W-1:0] o_control_effort,
    output logic signed [MEAS_OUT_W-1:0] o_measured_velocity
);

    localparam int W    = VEL_WIDTH;
    localparam int MA_W = W + 3;
    localparam int MP_W = MA_W + GAIN_W;
    localparam int PT_W = MP_W - PD_SHIFT;
    localparam int AC_W = PT_W + 2;
    localparam int XW   = (W > MEAS_OUT_W) ? W : MEAS_OUT_W;

    localparam logic signed [W-1:0] VEL_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VEL_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [MEAS_OUT_W-1:0] OUT_MAX = {1'b0, {(MEAS_OUT_W-1){1'b1}}};
    localparam logic signed [MEAS_OUT_W-1:0] OUT_MIN = {1'b1, {(MEAS_OUT_W-1){1'b0}}};

    // configuration
    logic [GAIN_W-1:0] r_prop_gain;
    logic [GAIN_W-1:0] r_deriv_gain;
    logic [GAIN_W-1:0] r_ramp_step;
    logic [GAIN_W-1:0] r_handle_gain;
    logic [GAIN_W-1:0] r_pwm_period;
    logic              r_dir_inv;

    // item and state
    logic signed [DELTA_W-1:0]  r_delta;
    logic signed [TARGET_W-1:0] r_target;
    logic                       r_en;
    logic signed [W-1:0]        r_vnow;
    logic signed [W-1:0]        r_prev;
    logic signed [W-1:0]        r_meas;
    logic signed [W-1:0]        r_sp;
    logic signed [W-1:0]        r_hist [HISTORY_DEPTH];
    logic signed [MA_W-1:0]     r_d;
    logic signed [PT_W-1:0]     r_pterm;
    logic signed [EFFORT_W-1:0] r_acc;

    // result
    logic [DUTY_W-1:0]            r_o_duty;
    logic                         r_o_dir;
    logic signed [EFFORT_W-1:0]   r_o_effort;
    logic signed [MEAS_OUT_W-1:0] r_o_meas;

    // combinational
    logic signed [DELTA_W+14:0] w_vprod;
    logic signed [W-1:0]        w_vnow;
    logic signed [W:0]          w_meas_sum;
    logic signed [W+1:0]        w_spx;
    logic signed [W+1:0]        w_tx;
    logic signed [W+1:0]        w_stepx;
    logic signed [W+1:0]        w_ramp;
    logic signed [MA_W-1:0]     w_mul_a;
    logic [GAIN_W-1:0]          w_mul_b;
    logic signed [MP_W-1:0]     w_prod;
    logic signed [MP_W-1:0]     w_scaled_x;
    logic signed [W-1:0]        w_scaled;
    logic signed [W:0]          w_err_x;
    logic signed [W-1:0]        w_e0;
    logic signed [W+3:0]        w_h03;
    logic signed [W+3:0]        w_h12;
    logic signed [W+3:0]        w_d_x;
    logic signed [MP_W-1:0]     w_pd;
    logic signed [AC_W-1:0]     w_acc_x;
    logic signed [EFFORT_W-1:0] w_acc;
    logic [EFFORT_W-1:0]        w_acc_mag;
    logic signed [XW-1:0]       w_meas_x;
    logic signed [MEAS_OUT_W-1:0] w_meas_out;
    logic [DUTY_W-1:0]          w_quot;
    logic                       w_mul_busy;
    logic                       w_mul_done;
    logic                       w_div_done;

    // encoder counts to velocity, saturated
    assign w_vprod = r_delta * $signed({1'b0, VEL_PER_COUNT});
    always_comb begin
        if (w_vprod > VEL_MAX) begin
            w_vnow = VEL_MAX;
        end else if (w_vprod < VEL_MIN) begin
            w_vnow = VEL_MIN;
        end else begin
            w_vnow = W'(w_vprod);
        end
    end

    // two-tick average, floor
    assign w_meas_sum = (W+1)'(r_vnow) + (W+1)'(r_prev);

    // ramp: result stays between old setpoint and target, so it fits
    assign w_spx   = (W+2)'(r_sp);
    assign w_tx    = (W+2)'(r_target);
    assign w_stepx = (W+2)'(r_ramp_step);
    always_comb begin
        w_ramp = w_spx;
        if (w_tx > w_spx) begin
            w_ramp = w_spx + w_stepx;
            if (w_tx < w_ramp) begin
                w_ramp = w_tx;
            end
        end else if (w_tx < w_spx) begin
            w_ramp = w_spx - w_stepx;
            if (w_tx > w_ramp) begin
                w_ramp = w_tx;
            end
        end
    end

    // multiplier operand select
    assign w_acc_mag = EFFORT_W'(r_acc[EFFORT_W-1] ? -r_acc : r_acc);
    always_comb begin
        case (i_cmd.mul_sel)
            MSEL_HG: begin
                w_mul_a = MA_W'(r_sp);
                w_mul_b = r_handle_gain;
            end
            MSEL_KP: begin
                w_mul_a = MA_W'(r_hist[0]);
                w_mul_b = r_prop_gain;
            end
            MSEL_KD: begin
                w_mul_a = r_d;
                w_mul_b = r_deriv_gain;
            end
            MSEL_PWM: begin
                w_mul_a = MA_W'({1'b0, w_acc_mag});
                w_mul_b = r_pwm_period;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    mvr_mul #(
        .A_W (MA_W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_prod  (w_prod),
        .o_busy  (w_mul_busy),
        .o_done  (w_mul_done)
    );

    mvr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_prod[PWM_NUM_W+PWM_PRE_SHIFT-1:PWM_PRE_SHIFT]),
        .o_quot  (w_quot),
        .o_done  (w_div_done)
    );

    // scaled setpoint and new error, both saturated
    assign w_scaled_x = w_prod >>> HG_SHIFT;
    always_comb begin
        if (w_scaled_x > VEL_MAX) begin
            w_scaled = VEL_MAX;
        end else if (w_scaled_x < VEL_MIN) begin
            w_scaled = VEL_MIN;
        end else begin
            w_scaled = W'(w_scaled_x);
        end
    end

    assign w_err_x = (W+1)'(w_scaled) - (W+1)'(r_meas);
    always_comb begin
        if (w_err_x > VEL_MAX) begin
            w_e0 = VEL_MAX;
        end else if (w_err_x < VEL_MIN) begin
            w_e0 = VEL_MIN;
        end else begin
            w_e0 = W'(w_err_x);
        end
    end

    // four-sample difference: (e0 - e3) + 3 * (e1 - e2)
    assign w_h03 = (W+4)'(r_hist[0]) - (W+4)'(r_hist[3]);
    assign w_h12 = (W+4)'(r_hist[1]) - (W+4)'(r_hist[2]);
    assign w_d_x = w_h03 + w_h12 + (w_h12 <<< 1);

    // accumulator update and clamp
    assign w_pd    = w_prod >>> PD_SHIFT;
    assign w_acc_x = AC_W'(r_acc) + AC_W'(r_pterm) + AC_W'(PT_W'(w_pd));
    always_comb begin
        if (w_acc_x > EFFORT_LIMIT) begin
            w_acc = EFFORT_LIMIT;
        end else if (w_acc_x < EFFORT_NEG) begin
            w_acc = EFFORT_NEG;
        end else begin
            w_acc = EFFORT_W'(w_acc_x);
        end
    end

    // measured velocity onto the 32-bit output
    assign w_meas_x = XW'(r_meas);
    always_comb begin
        if (w_meas_x > OUT_MAX) begin
            w_meas_out = OUT_MAX;
        end else if (w_meas_x < OUT_MIN) begin
            w_meas_out = OUT_MIN;
        end else begin
            w_meas_out = MEAS_OUT_W'(w_meas_x);
        end
    end

    // configuration writes, unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain   <= PROP_GAIN_RST;
            r_deriv_gain  <= DERIV_GAIN_RST;
            r_ramp_step   <= RAMP_STEP_RST;
            r_handle_gain <= HANDLE_GAIN_RST;
            r_pwm_period  <= PWM_PERIOD_RST;
            r_dir_inv     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PROP_GAIN:   r_prop_gain   <= i_cfg_wdata;
                CFG_DERIV_GAIN:  r_deriv_gain  <= i_cfg_wdata;
                CFG_RAMP_STEP:   r_ramp_step   <= i_cfg_wdata;
                CFG_HANDLE_GAIN: r_handle_gain <= i_cfg_wdata;
                CFG_PWM_PERIOD:  r_pwm_period  <= i_cfg_wdata;
                CFG_DIR_INVERT:  r_dir_inv     <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // controller state carried between ticks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_sp   <= '0;
            r_acc  <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
        end else begin
            if (i_cmd.calc_meas) begin
                r_prev <= r_vnow;
                if (r_en) begin
                    r_sp <= W'(w_ramp);
                end else begin
                    r_acc <= '0;
                end
            end
            if (i_cmd.calc_err) begin
                r_hist[0] <= w_e0;
                for (int i = 1; i < HISTORY_DEPTH; i++) begin
                    r_hist[i] <= r_hist[i-1];
                end
            end
            if (i_cmd.calc_acc) begin
                r_acc <= w_acc;
            end
        end
    end

    // per-item working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_delta  <= i_encoder_delta;
            r_target <= i_target_velocity;
            r_en     <= i_enable;
        end
        if (i_cmd.calc_vel) begin
            r_vnow <= w_vnow;
        end
        if (i_cmd.calc_meas) begin
            r_meas <= w_meas_sum[W:1];
        end
        if (i_cmd.calc_diff) begin
            r_d <= MA_W'(w_d_x);
        end
        if (i_cmd.latch_p) begin
            r_pterm <= PT_W'(w_pd);
        end
    end

    // result register; direction follows the accumulator sign unless inverted, low on zero duty
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_duty   <= r_en ? w_quot : '0;
            r_o_dir    <= r_en && (w_quot != '0) && (r_acc[EFFORT_W-1] ^ ~r_dir_inv);
            r_o_effort <= r_acc;
            r_o_meas   <= w_meas_out;
        end
    end

    assign o_status.enable   = r_en;
    assign o_status.mul_busy = w_mul_busy;
    assign o_status.mul_done = w_mul_done;
    assign o_status.div_done = w_div_done;

    assign o_pwm_duty          = r_o_duty;
    assign o_drive_direction   = r_o_dir;
    assign o_control_effort    = r_o_effort;
    assign o_measured_velocity = r_o_meas;

endmodule

/* sv/mvr_ctrl.sv */
// ---------------------------------------------------------------------------
// mvr_ctrl
// Sequencer for one control tick and the output beat handshake.
// ---------------------------------------------------------------------------
module mvr_ctrl import mvr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [15:0] {
        S_IDLE     = 16'h0001,
        S_VEL      = 16'h0002,
        S_MEAS     = 16'h0004,
        S_HG_GO    = 16'h0008,
        S_HG_WAIT  = 16'h0010,
        S_ERR      = 16'h0020,
        S_KP_GO    = 16'h0040,
        S_KP_WAIT  = 16'h0080,
        S_KD_GO    = 16'h0100,
        S_KD_WAIT  = 16'h0200,
        S_ACC      = 16'h0400,
        S_PWM_GO   = 16'h0800,
        S_PWM_WAIT = 16'h1000,
        S_DIV_GO   = 16'h2000,
        S_DIV_WAIT = 16'h4000,
        S_DONE     = 16'h8000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    t_dp_cmd w_cmd;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load_in = 1'b1;
                    n_state       = S_VEL;
                end
            end
            S_VEL: begin
                w_cmd.calc_vel = 1'b1;
                n_state        = S_MEAS;
            end
            S_MEAS: begin
                w_cmd.calc_meas = 1'b1;
                n_state         = i_status.enable ? S_HG_GO : S_DONE;
            end
            S_HG_GO: begin
                w_cmd.mul_start = 1'b1;
                w_cmd.mul_sel   = MSEL_HG;
                n_state         = S_HG_WAIT;
            end
            S_HG_WAIT: begin
                if (i_status.mul_done) n_state = S_ERR;
            end
            S_ERR: begin
                w_cmd.calc_err = 1'b1;
                n_state        = S_KP_GO;
            end
            S_KP_GO: begin
                w_cmd.mul_start = 1'b1;
                w_cmd.mul_sel   = MSEL_KP;
                w_cmd.calc_diff = 1'b1;
                n_state         = S_KP_WAIT;
            end
            S_KP_WAIT: begin
                if (i_status.mul_done) n_state = S_KD_GO;
            end
            S_KD_GO: begin
                w_cmd.latch_p   = 1'b1;
                w_cmd.mul_start = 1'b1;
                w_cmd.mul_sel   = MSEL_KD;
                n_state         = S_KD_WAIT;
            end
            S_KD_WAIT: begin
                if (i_status.mul_done) n_state = S_ACC;
            end
            S_ACC: begin
                w_cmd.calc_acc = 1'b1;
                n_state        = S_PWM_GO;
            end
            S_PWM_GO: begin
                w_cmd.mul_start = 1'b1;
                w_cmd.mul_sel   = MSEL_PWM;
                n_state         = S_PWM_WAIT;
            end
            S_PWM_WAIT: begin
                if (i_status.mul_done) n_state = S_DIV_GO;
            end
            S_DIV_GO: begin
                w_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_status.div_done) n_state = S_DONE;
            end
            S_DONE: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output beat valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        if (w_cmd.load_out)             n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: velocity ramp PD controller testbench
// Drives control ticks into the input stream, predicts each result beat with
// a cycle-free fixed-point copy of the axis state, and compares every output
// beat field by field. Register settings change only while the block is idle.
// ---------------------------------------------------------------------------
module tb import mvr_pkg::*; ();

    localparam int VEL_BITS    = 32;
    localparam int HOLD_CYCLES = 400;

    // register indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [DUTY_W-1:0]     duty;
        logic                  dir;
        logic [EFFORT_W-1:0]   effort;
        logic [MEAS_OUT_W-1:0] vel;
    } t_drive_result;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    always #1 i_clk = ~i_clk;

    // block ports
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // encoder_delta, target_velocity
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;  // enable
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // pwm_duty, drive_direction,
                                                // control_effort, measured_velocity

    motor_velocity_ramp_pd_controller #(
        .VEL_WIDTH(VEL_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // predictor copy of the registers
    logic [GAIN_W-1:0] kp_q12     = PROP_GAIN_RST;
    logic [GAIN_W-1:0] kd_q12     = DERIV_GAIN_RST;
    logic [GAIN_W-1:0] ramp_q8    = RAMP_STEP_RST;
    logic [GAIN_W-1:0] hg_q14     = HANDLE_GAIN_RST;
    logic [GAIN_W-1:0] period_cnt = PWM_PERIOD_RST;
    logic              dir_inv    = 1'b0;

    // predictor copy of the axis state
    longint axis_prev_vel = 0;
    longint axis_setpoint = 0;
    longint axis_err_hist [HISTORY_DEPTH] = '{default: 0};
    longint axis_effort   = 0;

    t_drive_result pending_drive_q [$];
    t_drive_result beat_got, beat_want;

    int  err_cnt      = 0;
    int  ticks_sent   = 0;
    int  results_seen = 0;
    int  cfg_writes   = 0;
    int  hold_seq     = 0;
    int  hold_seen    = 0;
    int  stall_left   = 0;
    logic sink_idle_en = 1'b1;
    bit  src_idle_en  = 1'b1;
    bit  src_offering = 1'b0;

    // saturate to the velocity width
    function automatic longint sat_vel(longint x);
        longint hi, lo;
        hi = (longint'(1) <<< (VEL_BITS - 1)) - 1;
        lo = -hi - 1;
        if (x > hi) return hi;
        if (x < lo) return lo;
        return x;
    endfunction

    // advance the axis by one tick and return the drive it produces
    function automatic t_drive_result predict_drive(logic signed [DELTA_W-1:0] delta,
            logic signed [TARGET_W-1:0] target, logic en);
        t_drive_result r;
        longint vnow, vel, sp, tgt, scaled, e0, diff, acc, pwm, per, lim, mag;
        int i;
        tgt  = longint'(target);
        per  = longint'(period_cnt);
        lim  = longint'(EFFORT_LIMIT);
        vnow = sat_vel(longint'(delta) * longint'(VEL_PER_COUNT));
        vel  = sat_vel((vnow + axis_prev_vel) >>> 1);
        axis_prev_vel = vnow;
        pwm = 0;
        if (en) begin
            // ramp toward the target, stopping on it
            sp = axis_setpoint;
            if (tgt > sp) begin
                sp = sp + longint'(ramp_q8);
                if (tgt < sp) sp = tgt;
            end else if (tgt < sp) begin
                sp = sp - longint'(ramp_q8);
                if (tgt > sp) sp = tgt;
            end
            axis_setpoint = sat_vel(sp);
            scaled = sat_vel((axis_setpoint * longint'(hg_q14)) >>> HG_SHIFT);
            e0 = sat_vel(scaled - vel);
            for (i = HISTORY_DEPTH - 1; i > 0; i--)
                axis_err_hist[i] = axis_err_hist[i-1];
            axis_err_hist[0] = e0;
            diff = (axis_err_hist[0] - axis_err_hist[HISTORY_DEPTH-1])
                 + 3 * (axis_err_hist[1] - axis_err_hist[2]);
            // incremental PD with clamped accumulator
            acc = axis_effort + ((longint'(kp_q12) * e0) >>> PD_SHIFT)
                + ((longint'(kd_q12) * diff) >>> PD_SHIFT);
            if (acc > lim) acc = lim;
            if (acc < -lim) acc = -lim;
            axis_effort = acc;
            pwm = (acc * per) / lim;
            if (pwm > per) pwm = per;
            if (pwm < -per) pwm = -per;
        end else begin
            axis_effort = 0;
        end
        mag = (pwm < 0) ? -pwm : pwm;
        r.duty   = mag[DUTY_W-1:0];
        r.dir    = (pwm > 0) ? !dir_inv : ((pwm < 0) ? dir_inv : 1'b0);
        r.effort = axis_effort[EFFORT_W-1:0];
        r.vel    = vel[MEAS_OUT_W-1:0];
        return r;
    endfunction

    // offer one tick beat and wait until it is taken
    task automatic send_tick(logic signed [DELTA_W-1:0] delta,
            logic signed [TARGET_W-1:0] target, logic en);
        int gap;
        if (src_idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 15);
            if (src_offering) s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {target, delta};
        s_axis_tuser  <= en;
        src_offering = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_drive_q.push_back(predict_drive(delta, target, en));
        ticks_sent++;
    endtask

    // stop offering and wait until every pending result has come out
    task automatic wait_idle();
        if (src_offering) s_axis_tvalid <= 1'b0;
        src_offering = 1'b0;
        while (pending_drive_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // one register write; the block is idle here
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_PROP_GAIN:   kp_q12     = value;
            CFG_DERIV_GAIN:  kd_q12     = value;
            CFG_RAMP_STEP:   ramp_q8    = value;
            CFG_HANDLE_GAIN: hg_q14     = value;
            CFG_PWM_PERIOD:  period_cnt = value;
            CFG_DIR_INVERT:  dir_inv    = value[0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic write_all_regs(logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] kd,
            logic [GAIN_W-1:0] step, logic [GAIN_W-1:0] hg, logic [GAIN_W-1:0] per,
            logic [CFG_DATA_W-1:0] inv);
        wait_idle();
        write_reg(CFG_PROP_GAIN, kp);
        write_reg(CFG_DERIV_GAIN, kd);
        write_reg(CFG_RAMP_STEP, step);
        write_reg(CFG_HANDLE_GAIN, hg);
        write_reg(CFG_PWM_PERIOD, per);
        write_reg(CFG_DIR_INVERT, inv);
    endtask

    // mostly closed-loop-looking runs, some disabled stretches, some noise
    task automatic run_random_ticks(int count);
        int done, seg, len, k, tgt_i, dlt;
        done = 0;
        while (done < count) begin
            seg = $urandom_range(0, 19);
            if (seg < 15) begin
                len = $urandom_range(8, 40);
                if ($urandom_range(0, 7) == 0) begin
                    tgt_i = $urandom_range(0, 16777215);
                    tgt_i = tgt_i - 8388608;
                end else begin
                    tgt_i = $urandom_range(0, 400000);
                    tgt_i = tgt_i - 200000;
                end
                for (k = 0; k < len && done < count; k++) begin
                    dlt = $urandom_range(0, 6);
                    dlt = dlt - 3 + tgt_i / 8543;
                    send_tick(DELTA_W'(dlt), TARGET_W'(tgt_i), 1'b1);
                    done++;
                end
            end else if (seg < 18) begin
                len = $urandom_range(1, 6);
                for (k = 0; k < len && done < count; k++) begin
                    dlt = $urandom_range(0, 60);
                    send_tick(DELTA_W'(dlt - 30), TARGET_W'($urandom), 1'b0);
                    done++;
                end
            end else begin
                len = $urandom_range(1, 4);
                for (k = 0; k < len && done < count; k++) begin
                    send_tick(DELTA_W'($urandom), TARGET_W'($urandom), 1'($urandom));
                    done++;
                end
            end
        end
    endtask

    // result checker and receiver ready pattern
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            beat_got.duty   = m_axis_tdata[DUTY_W-1:0];
            beat_got.dir    = m_axis_tdata[DUTY_W];
            beat_got.effort = m_axis_tdata[DUTY_W+1 +: EFFORT_W];
            beat_got.vel    = m_axis_tdata[DUTY_W+1+EFFORT_W +: MEAS_OUT_W];
            if (pending_drive_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("tb: result beat with no tick pending, data %h", m_axis_tdata);
            end else begin
                beat_want = pending_drive_q.pop_front();
                if (beat_got.duty !== beat_want.duty || beat_got.dir !== beat_want.dir ||
                    beat_got.effort !== beat_want.effort || beat_got.vel !== beat_want.vel)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("tb: beat %0d exp/got duty %0d/%0d dir %0b/%0b eff %0d/%0d vel %0d/%0d",
                            results_seen, beat_want.duty, beat_got.duty,
                            beat_want.dir, beat_got.dir,
                            $signed(beat_want.effort), $signed(beat_got.effort),
                            $signed(beat_want.vel), $signed(beat_got.vel));
                end
                results_seen++;
            end
        end
        // long hold-off on request, else random stall bursts
        if (hold_seq != hold_seen) begin
            hold_seen  = hold_seq;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left == 0 && sink_idle_en && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 15);
        if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // setpoint ramp and feedback at reset values, with a disable in between
    task automatic test_default_ramp();
        send_tick(16'sd0, 24'sd2000, 1'b1);
        send_tick(16'sd0, 24'sd2000, 1'b1);
        send_tick(16'sd0, 24'sd2000, 1'b1);
        send_tick(16'sd5, 24'sd2000, 1'b1);
        send_tick(16'sd2, 24'sd0, 1'b0);
        send_tick(-16'sd3, -24'sd5000, 1'b1);
    endtask

    // extremes of every input field, then of the ramp and handle gain
    task automatic test_field_extremes();
        send_tick(16'sh7FFF, 24'sh7FFFFF, 1'b1);
        send_tick(16'sh8000, 24'sh800000, 1'b1);
        send_tick(16'sh8000, 24'sh7FFFFF, 1'b1);
        send_tick(16'sh7FFF, 24'sh800000, 1'b0);
        send_tick(-16'sd1, -24'sd1, 1'b1);
        send_tick(16'sd1, 24'sd1, 1'b1);
        send_tick(16'sd0, 24'sd0, 1'b0);
        wait_idle();
        write_reg(CFG_RAMP_STEP, 16'hFFFF);
        write_reg(CFG_HANDLE_GAIN, 16'hFFFF);
        send_tick(16'sd0, 24'sh7FFFFF, 1'b1);
        send_tick(16'sd0, 24'sh800000, 1'b1);
        send_tick(16'sh7FFF, 24'sh7FFFFF, 1'b1);
    endtask

    // writes to undecoded indexes leave every register alone
    task automatic test_unknown_index();
        wait_idle();
        write_reg(CFG_SPARE_LO, 16'h0000);
        write_reg(CFG_SPARE_HI, 16'hFFFF);
        send_tick(-16'sd7, 24'sd300000, 1'b1);
        send_tick(16'sd9, -24'sd300000, 1'b1);
    endtask

    // a zero period forces zero drive while the accumulator keeps running
    task automatic test_zero_period();
        wait_idle();
        write_reg(CFG_PWM_PERIOD, 16'h0000);
        write_reg(CFG_PROP_GAIN, 16'd4096);
        send_tick(16'sd0, 24'sd600000, 1'b1);
        send_tick(-16'sd20, 24'sd600000, 1'b1);
        send_tick(16'sd40, -24'sd600000, 1'b1);
    endtask

    // all registers at their top, then at their bottom but for a pwm period of one
    task automatic test_register_extremes();
        write_all_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random_ticks(100);
        write_all_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'hFFFE);
        run_random_ticks(100);
    endtask

    // random register settings, typical values with the odd wild one
    task automatic test_random_settings();
        int ph;
        logic [GAIN_W-1:0] kp, kd, step, hg, per;
        for (ph = 0; ph < 5; ph++) begin
            kp   = ($urandom_range(0, 9) == 0) ? GAIN_W'($urandom) : GAIN_W'($urandom_range(200, 6000));
            kd   = ($urandom_range(0, 9) == 0) ? GAIN_W'($urandom) : GAIN_W'($urandom_range(200, 8000));
            step = ($urandom_range(0, 9) == 0) ? GAIN_W'($urandom) : GAIN_W'($urandom_range(16, 4000));
            hg   = ($urandom_range(0, 9) == 0) ? GAIN_W'($urandom) : GAIN_W'($urandom_range(8192, 24576));
            per  = ($urandom_range(0, 9) == 0) ? GAIN_W'($urandom_range(1, 65535))
                                               : GAIN_W'($urandom_range(1000, 20000));
            write_all_regs(kp, kd, step, hg, per, CFG_DATA_W'($urandom));
            run_random_ticks(220);
        end
    endtask

    // receiver holds off for a long stretch while ticks keep coming
    task automatic test_output_backpressure();
        wait_idle();
        hold_seq <= hold_seq + 1;
        src_idle_en = 1'b0;
        run_random_ticks(20);
        src_idle_en = 1'b1;
    endtask

    // sender pauses until the pipeline is empty, then resumes
    task automatic test_sender_pause();
        int k;
        for (k = 0; k < 3; k++) begin
            run_random_ticks(20);
            wait_idle();
            repeat ($urandom_range(20, 80)) @(posedge i_clk);
        end
    endtask

    // back-to-back traffic with both sides always ready
    task automatic test_no_idle();
        write_all_regs(PROP_GAIN_RST, DERIV_GAIN_RST, RAMP_STEP_RST, HANDLE_GAIN_RST,
                       PWM_PERIOD_RST, 16'h0001);
        sink_idle_en <= 1'b0;
        src_idle_en = 1'b0;
        run_random_ticks(150);
    endtask

    // test sequence
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_ramp();
        test_field_extremes();
        test_unknown_index();
        test_zero_period();
        test_register_extremes();
        test_random_settings();
        test_output_backpressure();
        test_sender_pause();
        test_no_idle();
        wait_idle();
        repeat (60) @(posedge i_clk);
        if (pending_drive_q.size() != 0) err_cnt++;
        $display("tb: %0d ticks sent, %0d result beats compared, %0d register writes",
                 ticks_sent, results_seen, cfg_writes);
        $display("tb: covered field and register extremes, zero period, spare indexes, hold-off");
        if (err_cnt == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
